@@ rtl/dbpl_pkg.sv @@
// Shared types and constants for the DSD bit-density peak level meter.
// No dependencies; used by the interfaces, controller, datapath and top level.
`default_nettype none

package dbpl_pkg;

   localparam int SAMPLE_W      = 16;
   localparam int DSD_W         = 8;
   localparam int POP_W         = 4;
   localparam int CSR_W         = 8;
   localparam logic [CSR_W-1:0] CSR_RESET = 8'd8;
   localparam int GROUP_LEN_MIN = 2;

   localparam int LEVEL_W = 15;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 15'h7FFF;

   // quotient bits kept before saturation; the root of a 30-bit value fits the level
   localparam int QUO_W = 30;
   localparam int STEP_W = 5;

   // 65534^2 = 2^32 - 2^18 + 2^2
   localparam int SCALE_HI  = 32;
   localparam int SCALE_MID = 18;
   localparam int SCALE_LO  = 2;

   typedef struct packed {
      logic take;
      logic square;
      logic window;
      logic peak;
      logic lv_sel;
      logic lv_mul;
      logic lv_num;
      logic div_init;
      logic root_zero;
      logic root_sat;
      logic div_step;
      logic sqrt_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic close;
      logic last;
      logic zero;
      logic sat;
   } status_type;

endpackage

`default_nettype wire

@@ rtl/dbpl_req_if.sv @@
// Request channel: one DoP frame word and its end-of-period mark.
// Depends on dbpl_pkg for field widths.
`default_nettype none

interface dbpl_req_if;
   logic                          valid;
   logic                          ready;
   logic [dbpl_pkg::SAMPLE_W-1:0] sample_word;
   logic                          last_of_period;

   modport source (output valid, output sample_word, output last_of_period, input ready);
   modport sink   (input valid, input sample_word, input last_of_period, output ready);
endinterface

`default_nettype wire

@@ rtl/dbpl_rsp_if.sv @@
// Response channel: the peak level of one period.
// Depends on dbpl_pkg for field widths.
`default_nettype none

interface dbpl_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [dbpl_pkg::LEVEL_W-1:0] level;

   modport source (output valid, output level, input ready);
   modport sink   (input valid, input level, output ready);
endinterface

`default_nettype wire

@@ rtl/dsd_bit_density_peak_level.sv @@
// Top level of the DSD bit-density peak level meter.
// Depends on dbpl_pkg, dbpl_req_if, dbpl_rsp_if, dbpl_ctrl and dbpl_datapath.
//
// Usage:
//   req carries one DoP frame word per request; the low eight bits are counted.
//   Requests with last_of_period low give no response. A request with
//   last_of_period high closes the period and gives one response on rsp with
//   the peak sliding RMS level, then clears the period state.
//   csr_we / csr_wdata write group_len (frames per group); write only when idle.
// Frame sequence (a new frame is taken only in the idle state):
//   a frame passes the group state, and the window and peak states when it closes
//   a group (square, window update, peak compare run in turn on one datapath).
// Closing frame:
//   select, multiply, numerator and saturation states, the 30-step restoring
//   divider and the 15-step square root, then output; select skips to output
//   when no group completed, and the saturation state when the level saturates.
// Reset:
//   Synchronous, active high; clears the period state, sets group_len to 8.
// Stall:
//   The level sits in an output register; frames are still taken while it waits,
//   and a further level waits in the sequencer until the register frees.
`default_nettype none

module dsd_bit_density_peak_level #(
   parameter int WINDOW_GROUPS = 2,
   parameter int MAX_GROUP_LEN = 255
) (
   input  wire                          clock,
   input  wire                          reset,
   dbpl_req_if.sink                     req,
   dbpl_rsp_if.source                   rsp,
   input  wire                          csr_we,
   input  wire  [dbpl_pkg::CSR_W-1:0]   csr_wdata
);

   dbpl_pkg::cmd_type    cmd;
   dbpl_pkg::status_type st;

   dbpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .st        (st),
      .cmd       (cmd)
   );

   dbpl_datapath #(
      .WINDOW_GROUPS (WINDOW_GROUPS),
      .MAX_GROUP_LEN (MAX_GROUP_LEN)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .sample_word    (req.sample_word),
      .last_of_period (req.last_of_period),
      .cmd            (cmd),
      .st             (st),
      .level          (rsp.level)
   );

endmodule

`default_nettype wire

@@ rtl/dbpl_ctrl.sv @@
// Sequencer for the level meter: steps the datapath through group close,
// window update and the divide / square-root back end. Depends on dbpl_pkg.
`default_nettype none

module dbpl_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   input  dbpl_pkg::status_type  st,
   output dbpl_pkg::cmd_type     cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GROUP,
      ST_WINDOW,
      ST_PEAK,
      ST_LV_SEL,
      ST_LV_MUL,
      ST_LV_NUM,
      ST_LV_SAT,
      ST_DIV,
      ST_SQRT,
      ST_OUT
   } state_type;

   state_type                     state_ff;
   logic [dbpl_pkg::STEP_W-1:0]   cnt_ff;
   logic                          rsp_valid_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd           = '0;
      cmd.take      = (state_ff == ST_IDLE) && req_valid;
      cmd.square    = (state_ff == ST_GROUP) && st.close;
      cmd.window    = (state_ff == ST_WINDOW);
      cmd.peak      = (state_ff == ST_PEAK);
      cmd.lv_sel    = (state_ff == ST_LV_SEL);
      cmd.root_zero = (state_ff == ST_LV_SEL) && st.zero;
      cmd.lv_mul    = (state_ff == ST_LV_MUL);
      cmd.lv_num    = (state_ff == ST_LV_NUM);
      cmd.div_init  = (state_ff == ST_LV_SAT);
      cmd.root_sat  = (state_ff == ST_LV_SAT) && st.sat;
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.sqrt_step = (state_ff == ST_SQRT);
      cmd.out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_GROUP;
               end
            end
            ST_GROUP: begin
               if (st.close) begin
                  state_ff <= ST_WINDOW;
               end else if (st.last) begin
                  state_ff <= ST_LV_SEL;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_WINDOW: begin
               state_ff <= ST_PEAK;
            end
            ST_PEAK: begin
               state_ff <= st.last ? ST_LV_SEL : ST_IDLE;
            end
            ST_LV_SEL: begin
               state_ff <= st.zero ? ST_OUT : ST_LV_MUL;
            end
            ST_LV_MUL: begin
               state_ff <= ST_LV_NUM;
            end
            ST_LV_NUM: begin
               state_ff <= ST_LV_SAT;
            end
            ST_LV_SAT: begin
               cnt_ff   <= '0;
               state_ff <= st.sat ? ST_OUT : ST_DIV;
            end
            ST_DIV: begin
               if (cnt_ff == dbpl_pkg::STEP_W'(dbpl_pkg::QUO_W - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_SQRT;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_SQRT: begin
               if (cnt_ff == dbpl_pkg::STEP_W'(dbpl_pkg::LEVEL_W - 1)) begin
                  state_ff <= ST_OUT;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("response raised outside the output state");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff < dbpl_pkg::STEP_W'(dbpl_pkg::QUO_W)))
      else $error("divide step count overran");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff)
      else $error("response dropped while stalled");

endmodule

`default_nettype wire

@@ rtl/dbpl_datapath.sv @@
// Datapath for the level meter: ones counting, group squares, sliding window
// sum and peak, then a restoring divider and digit-by-digit square root.
// Depends on dbpl_pkg; driven by dbpl_ctrl through cmd_type.
`default_nettype none

module dbpl_datapath #(
   parameter int WINDOW_GROUPS = 2,
   parameter int MAX_GROUP_LEN = 255
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_we,
   input  wire  [dbpl_pkg::CSR_W-1:0]         csr_wdata,
   input  wire  [dbpl_pkg::SAMPLE_W-1:0]      sample_word,
   input  wire                                last_of_period,
   input  dbpl_pkg::cmd_type                  cmd,
   output dbpl_pkg::status_type               st,
   output logic [dbpl_pkg::LEVEL_W-1:0]       level
);

   localparam int LEN_W  = $clog2(MAX_GROUP_LEN + 1);
   localparam int CMP_W  = (LEN_W > dbpl_pkg::CSR_W) ? LEN_W : dbpl_pkg::CSR_W;
   localparam int H_W    = LEN_W + 2;
   localparam int CNT_W  = LEN_W + 3;
   localparam int SQ_W   = 2 * CNT_W;
   localparam int SUM_W  = SQ_W + $clog2(WINDOW_GROUPS);
   localparam int SLOT_W = (WINDOW_GROUPS > 1) ? $clog2(WINDOW_GROUPS) : 1;
   localparam int GD_W   = $clog2(WINDOW_GROUPS + 1);
   localparam int HH_W   = 2 * H_W;
   localparam int DEN_W  = HH_W + GD_W;
   localparam int NUM_W  = SUM_W + dbpl_pkg::SCALE_HI + 1;
   localparam int DSH_W  = DEN_W + dbpl_pkg::QUO_W - 1;
   localparam int DIV_W  = (NUM_W > DSH_W) ? NUM_W : DSH_W;
   localparam int SAT_W  = (NUM_W > DEN_W + dbpl_pkg::QUO_W) ? NUM_W
                                                             : DEN_W + dbpl_pkg::QUO_W;
   localparam int RW     = dbpl_pkg::QUO_W;

   logic [dbpl_pkg::CSR_W-1:0] gl_ff;
   logic [LEN_W-1:0]           len_ff;
   logic                       last_ff;
   logic [CNT_W-1:0]           ones_ff;
   logic [LEN_W-1:0]           frame_ff;
   logic [SQ_W-1:0]            sq_ff;
   logic [SQ_W-1:0]            ring_ff [WINDOW_GROUPS];
   logic [SUM_W-1:0]           sum_ff;
   logic [SUM_W-1:0]           peak_ff;
   logic [GD_W-1:0]            gd_ff;
   logic [SLOT_W-1:0]          slot_ff;
   logic [SUM_W-1:0]           s_ff;
   logic [GD_W-1:0]            k_ff;
   logic [HH_W-1:0]            hh_ff;
   logic [NUM_W-1:0]           num_ff;
   logic [DEN_W-1:0]           den_ff;
   logic [NUM_W-1:0]           rem_ff;
   logic [DSH_W-1:0]           dsh_ff;
   logic [dbpl_pkg::QUO_W-1:0] q_ff;
   logic [RW-1:0]              r_ff;
   logic [RW-1:0]              bit_ff;
   logic [dbpl_pkg::LEVEL_W-1:0] level_ff;

   logic [CMP_W-1:0]          gl_x;
   logic [LEN_W-1:0]          len_in;
   logic [dbpl_pkg::POP_W-1:0] pop;
   logic [CNT_W-1:0]          ones_in;
   logic [CNT_W-1:0]          h_x;
   logic [CNT_W-1:0]          diff;
   logic [SQ_W-1:0]           sq_in;
   logic [SUM_W-1:0]          sum_in;
   logic [SLOT_W-1:0]         slot_in;
   logic [GD_W-1:0]           gd_in;
   logic [H_W-1:0]            h;
   logic [DIV_W-1:0]          rem_x;
   logic [DIV_W-1:0]          dsh_x;
   logic                      fits;
   logic [RW-1:0]             trial;

   always_comb begin
      gl_x = CMP_W'(gl_ff);
      if (gl_x < CMP_W'(dbpl_pkg::GROUP_LEN_MIN)) begin
         len_in = LEN_W'(dbpl_pkg::GROUP_LEN_MIN);
      end else if (gl_x > CMP_W'(MAX_GROUP_LEN)) begin
         len_in = LEN_W'(MAX_GROUP_LEN);
      end else begin
         len_in = LEN_W'(gl_x);
      end
   end

   always_comb begin
      pop = '0;
      for (int i = 0; i < dbpl_pkg::DSD_W; i++) begin
         pop = pop + dbpl_pkg::POP_W'(sample_word[i]);
      end
   end

   assign ones_in = ones_ff + CNT_W'(pop);
   assign h       = {len_ff, 2'b00};
   assign h_x     = CNT_W'(h);
   assign diff    = (ones_ff >= h_x) ? (ones_ff - h_x) : (h_x - ones_ff);
   assign sq_in   = SQ_W'(diff) * SQ_W'(diff);
   assign sum_in  = sum_ff - SUM_W'(ring_ff[slot_ff]) + SUM_W'(sq_ff);
   assign slot_in = (slot_ff == SLOT_W'(WINDOW_GROUPS - 1)) ? '0 : slot_ff + 1'b1;
   assign gd_in   = (gd_ff == GD_W'(WINDOW_GROUPS)) ? gd_ff : gd_ff + 1'b1;

   assign rem_x = DIV_W'(rem_ff);
   assign dsh_x = DIV_W'(dsh_ff);
   assign fits  = (rem_x >= dsh_x);
   assign trial = r_ff + bit_ff;

   assign st.close = (frame_ff >= len_ff);
   assign st.last  = last_ff;
   assign st.zero  = (gd_ff == '0);
   assign st.sat   = (SAT_W'(num_ff) >= (SAT_W'(den_ff) << dbpl_pkg::QUO_W));

   assign level = level_ff;

   // period state and the group length register
   always_ff @(posedge clock) begin
      if (reset) begin
         gl_ff    <= dbpl_pkg::CSR_RESET;
         ones_ff  <= '0;
         frame_ff <= '0;
         sum_ff   <= '0;
         peak_ff  <= '0;
         gd_ff    <= '0;
         slot_ff  <= '0;
         for (int i = 0; i < WINDOW_GROUPS; i++) begin
            ring_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            gl_ff <= csr_wdata;
         end
         if (cmd.take) begin
            ones_ff  <= ones_in;
            frame_ff <= frame_ff + 1'b1;
         end
         if (cmd.square) begin
            ones_ff  <= '0;
            frame_ff <= '0;
         end
         if (cmd.window) begin
            sum_ff           <= sum_in;
            ring_ff[slot_ff] <= sq_ff;
            slot_ff          <= slot_in;
            gd_ff            <= gd_in;
         end
         if (cmd.peak && (gd_ff == GD_W'(WINDOW_GROUPS)) && (sum_ff > peak_ff)) begin
            peak_ff <= sum_ff;
         end
         if (cmd.out_load) begin
            ones_ff  <= '0;
            frame_ff <= '0;
            sum_ff   <= '0;
            peak_ff  <= '0;
            gd_ff    <= '0;
            slot_ff  <= '0;
            for (int i = 0; i < WINDOW_GROUPS; i++) begin
               ring_ff[i] <= '0;
            end
         end
      end
   end

   // frame and square capture, and the level back end
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         last_ff <= last_of_period;
         len_ff  <= len_in;
      end
      if (cmd.square) begin
         sq_ff <= sq_in;
      end
      if (cmd.lv_sel) begin
         if (gd_ff < GD_W'(WINDOW_GROUPS)) begin
            s_ff <= sum_ff;
            k_ff <= gd_ff;
         end else begin
            s_ff <= peak_ff;
            k_ff <= GD_W'(WINDOW_GROUPS);
         end
         hh_ff <= HH_W'(h) * HH_W'(h);
      end
      if (cmd.lv_mul) begin
         num_ff <= (NUM_W'(s_ff) << dbpl_pkg::SCALE_HI) + (NUM_W'(s_ff) << dbpl_pkg::SCALE_LO);
         den_ff <= DEN_W'(k_ff) * DEN_W'(hh_ff);
      end
      if (cmd.lv_num) begin
         num_ff <= num_ff - (NUM_W'(s_ff) << dbpl_pkg::SCALE_MID);
      end
      if (cmd.div_init) begin
         rem_ff <= num_ff;
         dsh_ff <= DSH_W'(den_ff) << (dbpl_pkg::QUO_W - 1);
         q_ff   <= '0;
         r_ff   <= cmd.root_sat ? RW'(dbpl_pkg::LEVEL_MAX) : '0;
         bit_ff <= RW'(1) << (2 * (dbpl_pkg::LEVEL_W - 1));
      end
      if (cmd.root_zero) begin
         r_ff <= '0;
      end
      if (cmd.div_step) begin
         if (fits) begin
            rem_ff <= NUM_W'(rem_x - dsh_x);
         end
         q_ff   <= {q_ff[dbpl_pkg::QUO_W-2:0], fits};
         dsh_ff <= dsh_ff >> 1;
      end
      if (cmd.sqrt_step) begin
         if (q_ff >= trial) begin
            q_ff <= q_ff - trial;
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.out_load) begin
         level_ff <= r_ff[dbpl_pkg::LEVEL_W-1:0];
      end
   end

   a_groups_bound: assert property (@(posedge clock) disable iff (reset)
      gd_ff <= GD_W'(WINDOW_GROUPS))
      else $error("completed group count past window size");

   a_peak_holds: assert property (@(posedge clock) disable iff (reset)
      cmd.peak && (gd_ff == GD_W'(WINDOW_GROUPS)) |=> (peak_ff >= sum_ff))
      else $error("peak below full window sum");

   a_root_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (r_ff[RW-1:dbpl_pkg::LEVEL_W] == '0))
      else $error("root wider than level");

endmodule

`default_nettype wire

@@ sim/tb_dsd_bit_density_peak_level.sv @@
// Self-checking bench for dsd_bit_density_peak_level: directed table, then random periods.
// Levels are predicted per accepted request and compared in order against the rsp channel.
// Depends on dbpl_pkg, dbpl_req_if, dbpl_rsp_if and the top level of the block.
`timescale 1ns / 100ps

module tb_dsd_bit_density_peak_level;

   localparam int WIN_GROUPS   = 2;
   localparam int DRAIN_CYCLES = 100;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_QUOTA  = 80;
   localparam longint unsigned SCALE_SQ = 64'd65534 * 64'd65534;

   typedef enum logic {ROW_FRAME, ROW_CSR} row_kind_type;
   typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS, FILL_DENSE, FILL_SPARSE} fill_type;

   typedef struct packed {
      row_kind_type                 kind;
      logic [15:0]                  word;
      logic                         last;
      logic                         known;
      logic [dbpl_pkg::LEVEL_W-1:0] lvl;
   } plan_row_type;

   localparam int PLAN_LEN = 31;
   localparam plan_row_type PLAN [PLAN_LEN] = '{
      '{ROW_FRAME, 16'h00FF, 1'b1, 1'b1, 15'd0},
      '{ROW_CSR,   16'd2,    1'b0, 1'b0, 15'd0},
      '{ROW_FRAME, 16'hFF00, 1'b0, 1'b0, 15'd0},
      '{ROW_FRAME, 16'h0000, 1'b1, 1'b1, 15'h7FFF},
      '{ROW_FRAME, 16'hFF55, 1'b0, 1'b0, 15'd0},
      '{ROW_FRAME, 16'h00AA, 1'b0, 1'b0, 15'd0},
      '{ROW_FRAME, 16'h5555, 1'b0, 1'b0, 15'd0},
      '{ROW_FRAME, 16'hAAAA, 1'b1, 1'b1, 15'd0},
      '{ROW_FRAME, 16'hAA0F, 1'b0, 1'b0, 15'd0},
      '{ROW_FRAME, 16'h00F0, 1'b0, 1'b0, 15'd0},
      '{ROW_FRAME, 16'h0001, 1'b1, 1'b1, 15'd0},
      '{ROW_CSR,   16'd0,    1'b0, 1'b0, 15'd0},
      '{ROW_FRAME, 16'h0000, 1'b0, 1'b0, 15'd0},
      '{ROW_FRAME, 16'h8000, 1'b1, 1'b1, 15'h7FFF},
      '{ROW_CSR,   16'd1,    1'b0, 1'b0, 15'd0},
      '{ROW_FRAME, 16'h7F01, 1'b0, 1'b0, 15'd0},
      '{ROW_FRAME, 16'h0003, 1'b1, 1'b0, 15'd0},
      '{ROW_CSR,   16'd255,  1'b0, 1'b0, 15'd0},
      '{ROW_FRAME, 16'hFFFF, 1'b1, 1'b1, 15'd0},
      '{ROW_CSR,   16'd4,    1'b0, 1'b0, 15'd0},
      '{ROW_FRAME, 16'h00FF, 1'b0, 1'b0, 15'd0},
      '{ROW_FRAME, 16'h0001, 1'b0, 1'b0, 15'd0},
      '{ROW_CSR,   16'd2,    1'b0, 1'b0, 15'd0},
      '{ROW_FRAME, 16'h0000, 1'b1, 1'b0, 15'd0},
      '{ROW_CSR,   16'd3,    1'b0, 1'b0, 15'd0},
      '{ROW_FRAME, 16'h0003, 1'b0, 1'b0, 15'd0},
      '{ROW_FRAME, 16'h0007, 1'b0, 1'b0, 15'd0},
      '{ROW_FRAME, 16'h000F, 1'b0, 1'b0, 15'd0},
      '{ROW_FRAME, 16'h0100, 1'b0, 1'b0, 15'd0},
      '{ROW_FRAME, 16'h0080, 1'b0, 1'b0, 15'd0},
      '{ROW_FRAME, 16'h00FE, 1'b1, 1'b0, 15'd0}
   };

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_we;
   logic [dbpl_pkg::CSR_W-1:0] csr_wdata;

   dbpl_req_if req ();
   dbpl_rsp_if rsp ();

   dsd_bit_density_peak_level DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // level predictor state; squares can pass 21 bits after a mid-period length cut
   logic [7:0]  grp_len = dbpl_pkg::CSR_RESET;
   logic [10:0] pop_acc = '0;
   logic [7:0]  frame_cnt = '0;
   logic [21:0] sq_ring [WIN_GROUPS] = '{default: '0};
   logic [22:0] ring_sum = '0;
   logic [22:0] ring_peak = '0;
   logic [1:0]  grp_done = '0;
   logic        ring_pos = 1'b0;

   logic [dbpl_pkg::LEVEL_W-1:0] levels_due [$];

   int errors = 0;
   int sent = 0;
   int checked = 0;
   int len_writes = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   bit hold_req = 1'b0;

   function automatic longint unsigned floor_root(input longint unsigned x);
      longint unsigned lo, hi, mid;
      lo = 0;
      hi = 64'd1 << 28;
      while (hi - lo > 1) begin
         mid = (lo + hi) >> 1;
         if (mid * mid <= x) lo = mid;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic void fold_frame(input logic [15:0] w, input logic last,
                                      output bit emits,
                                      output logic [dbpl_pkg::LEVEL_W-1:0] lvl);
      longint unsigned eff, h, c, d, sq, s, k, q;
      eff = (grp_len < 2) ? 2 : grp_len;
      h = 4 * eff;
      pop_acc = pop_acc + 11'($countones(w[7:0]));
      frame_cnt = frame_cnt + 1'b1;
      if (frame_cnt >= eff) begin
         c = pop_acc;
         d = (c >= h) ? c - h : h - c;
         sq = d * d;
         ring_sum = ring_sum + 23'(sq) - sq_ring[ring_pos];
         sq_ring[ring_pos] = 22'(sq);
         ring_pos = ring_pos + 1'b1;
         if (grp_done < WIN_GROUPS) grp_done = grp_done + 1'b1;
         if (grp_done >= WIN_GROUPS && ring_sum > ring_peak) ring_peak = ring_sum;
         pop_acc = '0;
         frame_cnt = '0;
      end
      emits = last;
      lvl = '0;
      if (last) begin
         if (grp_done > 0) begin
            if (grp_done < WIN_GROUPS) begin
               s = ring_sum;
               k = grp_done;
            end else begin
               s = ring_peak;
               k = WIN_GROUPS;
            end
            q = floor_root(SCALE_SQ * s / (k * h * h));
            lvl = (q > dbpl_pkg::LEVEL_MAX) ? dbpl_pkg::LEVEL_MAX
                                            : q[dbpl_pkg::LEVEL_W-1:0];
         end
         pop_acc = '0;
         frame_cnt = '0;
         sq_ring = '{default: '0};
         ring_sum = '0;
         ring_peak = '0;
         grp_done = '0;
         ring_pos = 1'b0;
      end
   endfunction

   function automatic logic [15:0] pick_word(input fill_type fill);
      logic [15:0] w;
      w = 16'($urandom);
      case (fill)
         FILL_ONES:   w[7:0] = 8'hFF;
         FILL_ZEROS:  w[7:0] = 8'h00;
         FILL_DENSE:  w[7:0] = 8'($urandom | $urandom);
         FILL_SPARSE: w[7:0] = 8'($urandom & $urandom);
         default:     w[7:0] = 8'($urandom);
      endcase
      return w;
   endfunction

   function automatic logic [7:0] pick_len();
      int r;
      r = $urandom_range(19);
      if (r == 0) return 8'd0;
      if (r == 1) return 8'd1;
      if (r < 16) return 8'($urandom_range(2, 10));
      if (r < 19) return 8'($urandom_range(11, 48));
      return 8'($urandom_range(49, 254));
   endfunction

   task automatic send_frame(input logic [15:0] w, input logic last, input logic known,
                             input logic [dbpl_pkg::LEVEL_W-1:0] known_lvl);
      bit emits;
      logic [dbpl_pkg::LEVEL_W-1:0] lvl;
      while ($urandom_range(99) < idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.sample_word <= w;
      req.last_of_period <= last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      fold_frame(w, last, emits, lvl);
      if (emits) levels_due.push_back(known ? known_lvl : lvl);
      sent++;
      @(negedge clock);
   endtask

   // group_len may only change once all levels are out and the back end is quiet
   task automatic write_group_len(input logic [7:0] v);
      req.valid <= 1'b0;
      while (levels_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      grp_len = v;
      len_writes++;
   endtask

   task automatic run_phase(input int idle, input int stall, input int quota);
      int unsigned eff, ngroups, partial, total, cut;
      int done_items;
      fill_type fill;
      idle_pct = idle;
      stall_pct = stall;
      done_items = 0;
      while (done_items < quota) begin
         if ($urandom_range(3) == 0) write_group_len(pick_len());
         eff = (grp_len < 2) ? 2 : grp_len;
         if (eff <= 10) ngroups = $urandom_range(5);
         else if (eff <= 48) ngroups = $urandom_range(2);
         else ngroups = $urandom_range(1);
         partial = ($urandom_range(2) == 0) ? $urandom_range((eff - 1 < 6) ? eff - 1 : 6) : 0;
         total = ngroups * eff + partial;
         if (total == 0) total = 1;
         cut = ($urandom_range(5) == 0 && total > 1) ? $urandom_range(1, total - 1) : 0;
         fill = fill_type'($urandom_range(4));
         for (int i = 0; i < total; i++) begin
            if (cut != 0 && i == cut) write_group_len(pick_len());
            send_frame(pick_word(($urandom_range(3) == 0) ? fill_type'($urandom_range(4))
                                                          : fill),
                       i == total - 1, 1'b0, '0);
            done_items++;
         end
      end
   endtask

   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin : level_check
      logic [dbpl_pkg::LEVEL_W-1:0] want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (levels_due.size() == 0) begin
            $error("level: none expected, actual %0d", rsp.level);
            errors++;
         end else begin
            want = levels_due.pop_front();
            checked++;
            if (rsp.level !== want) begin
               $error("level: expected %0d, actual %0d", want, rsp.level);
               errors++;
            end
         end
      end
   end

   initial begin
      #3ms;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.sample_word = '0;
      req.last_of_period = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < PLAN_LEN; i++) begin
         if (PLAN[i].kind == ROW_CSR) write_group_len(PLAN[i].word[7:0]);
         else send_frame(PLAN[i].word, PLAN[i].last, PLAN[i].known, PLAN[i].lvl);
      end

      // stall the response side so that the block backs up onto req
      write_group_len(8'd2);
      hold_req = 1'b1;
      for (int i = 0; i < 40; i++) begin
         send_frame(pick_word(fill_type'($urandom_range(4))), i[0], 1'b0, '0);
      end

      run_phase(0, 0, PHASE_QUOTA);
      run_phase(60, 0, PHASE_QUOTA);
      run_phase(0, 60, PHASE_QUOTA);

      // one full group at the longest length
      write_group_len(8'd255);
      for (int i = 0; i < 255; i++) send_frame(pick_word(FILL_DENSE), i == 254, 1'b0, '0);
      run_phase(15, 15, PHASE_QUOTA);

      req.valid <= 1'b0;
      while (levels_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("%0d requests over four idle/stall mixes and one held-off burst", sent);
      $display("%0d levels checked, %0d group_len writes, %0d errors",
               checked, len_writes, errors);
      if (errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
